>>> sv/xrng_pkg.sv
// ----------------------------------------------------------------------------
// xrng_pkg
// Shared types, constants and helpers of the xoshiro256++ bounded RNG core.
// ----------------------------------------------------------------------------
package xrng_pkg;

   // Field and state geometry
   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 4;
   localparam int IDX_W     = 2;
   localparam int OPC_W     = 2;
   localparam int STAT_W    = 2;

   // Generator rotate and shift amounts
   localparam int ROT_SUM = 23;
   localparam int SHIFT_T = 17;
   localparam int ROT_S3  = 45;

   typedef enum logic [OPC_W-1:0] {
      OP_RAW     = 2'd0,
      OP_BOUNDED = 2'd1,
      OP_RESEED  = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_SEED  = 2'd1,
      ST_NOT_SEEDED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RAW,
      S_LIMIT,
      S_DRAW,
      S_MOD,
      S_FINISH
   } fsm_type;

   // Commands from the sequencer to the generator
   typedef struct packed {
      logic load;
      logic step;
   } gen_cmd_type;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] seed_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int k);
      rotl = (x << k) | (x >> (WORD_W - k));
   endfunction

endpackage

>>> sv/xoshiro256pp_bounded_rng_core.sv
// ----------------------------------------------------------------------------
// xoshiro256pp_bounded_rng_core
// A raw draw steps the generator and waits for its output pipeline. Reseed,
// degenerate range or error go straight to the response. A bounded draw runs
// two bit-serial remainders, rejection limit then value, redrawing below it.
// One request in flight; the next is taken the cycle after the response loads.
// Reset (synchronous): generator marked not seeded, seed registers cleared.
// ----------------------------------------------------------------------------
module xoshiro256pp_bounded_rng_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [xrng_pkg::OPC_W-1:0]    req_opcode,
   input  logic [xrng_pkg::WORD_W-1:0]   req_range_low,
   input  logic [xrng_pkg::WORD_W-1:0]   req_range_high,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [xrng_pkg::WORD_W-1:0]   rsp_value,
   output logic [xrng_pkg::STAT_W-1:0]   rsp_status,
   // register write port
   input  logic                          csr_we,
   input  logic [xrng_pkg::IDX_W-1:0]    csr_index,
   input  logic [xrng_pkg::WORD_W-1:0]   csr_wdata
);

   localparam int W = xrng_pkg::WORD_W;

   xrng_pkg::fsm_type     state_ff, state_in;
   xrng_pkg::opcode_type  op_ff, op_in;
   xrng_pkg::status_type  status_ff, status_in;
   logic [W-1:0]          lo_ff, lo_in;
   logic [W-1:0]          span_ff, span_in;
   logic                  le_ff, le_in;
   logic [W-1:0]          limit_ff, limit_in;
   logic [W-1:0]          value_ff, value_in;
   xrng_pkg::seed_type    seed_ff;
   logic                  seed_zero;

   logic                  rsp_valid_ff;
   logic [W-1:0]          rsp_value_ff;
   xrng_pkg::status_type  rsp_status_ff;
   logic                  rsp_load;

   xrng_pkg::gen_cmd_type gen_cmd;
   logic                  gen_seeded, gen_busy, gen_out_valid;
   logic [W-1:0]          gen_out;

   logic                  div_start, div_busy, div_done;
   logic [W-1:0]          div_dividend, div_rem;

   // Seed registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_we) begin
         seed_ff[csr_index] <= csr_wdata;
      end
   end

   assign seed_zero = ~|seed_ff;

   xrng_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .cmd       (gen_cmd),
      .seed      (seed_ff),
      .seeded    (gen_seeded),
      .busy      (gen_busy),
      .out_valid (gen_out_valid),
      .out_word  (gen_out)
   );

   xrng_div #(
      .WIDTH (W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (span_ff),
      .busy     (div_busy),
      .done     (div_done),
      .rem      (div_rem)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      le_in        = le_ff;
      limit_in     = limit_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      gen_cmd      = '0;
      div_start    = 1'b0;
      div_dividend = gen_out;
      rsp_load     = 1'b0;
      case (state_ff)
         xrng_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in    = xrng_pkg::opcode_type'(req_opcode);
               lo_in    = req_range_low;
               span_in  = req_range_high - req_range_low;
               le_in    = (req_range_high <= req_range_low);
               state_in = xrng_pkg::S_DECODE;
            end
         end
         xrng_pkg::S_DECODE: begin
            value_in  = '0;
            status_in = xrng_pkg::ST_OK;
            state_in  = xrng_pkg::S_FINISH;
            case (op_ff)
               xrng_pkg::OP_RESEED: begin
                  if (seed_zero) begin
                     status_in = xrng_pkg::ST_ZERO_SEED;
                  end else begin
                     gen_cmd.load = 1'b1;
                  end
               end
               xrng_pkg::OP_RAW: begin
                  if (!gen_seeded) begin
                     status_in = xrng_pkg::ST_NOT_SEEDED;
                  end else begin
                     gen_cmd.step = 1'b1;
                     state_in     = xrng_pkg::S_RAW;
                  end
               end
               xrng_pkg::OP_BOUNDED: begin
                  if (!gen_seeded) begin
                     status_in = xrng_pkg::ST_NOT_SEEDED;
                  end else if (le_ff || span_ff == W'(1)) begin
                     value_in = lo_ff;
                  end else begin
                     // rejection limit = (2^64 - span) mod span
                     div_start    = 1'b1;
                     div_dividend = '0 - span_ff;
                     state_in     = xrng_pkg::S_LIMIT;
                  end
               end
               default: begin
               end
            endcase
         end
         xrng_pkg::S_RAW: begin
            if (gen_out_valid) begin
               value_in = gen_out;
               state_in = xrng_pkg::S_FINISH;
            end
         end
         xrng_pkg::S_LIMIT: begin
            if (div_done) begin
               limit_in     = div_rem;
               gen_cmd.step = 1'b1;
               state_in     = xrng_pkg::S_DRAW;
            end
         end
         xrng_pkg::S_DRAW: begin
            // redraw while below the rejection limit
            if (gen_out_valid) begin
               if (gen_out < limit_ff) begin
                  gen_cmd.step = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = xrng_pkg::S_MOD;
               end
            end
         end
         xrng_pkg::S_MOD: begin
            if (div_done) begin
               value_in = lo_ff + div_rem;
               state_in = xrng_pkg::S_FINISH;
            end
         end
         xrng_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = xrng_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = xrng_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xrng_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      lo_ff     <= lo_in;
      span_ff   <= span_in;
      le_ff     <= le_in;
      limit_ff  <= limit_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_value_ff  <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign req_ready  = (state_ff == xrng_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // A failed request never carries a value
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != xrng_pkg::ST_OK) |-> (rsp_value == '0))
      else $error("nonzero value with error status");

   // The remainder unit is never restarted while it runs
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // The generator only advances from a seeded state
   a_step_seeded: assert property (@(posedge clock) disable iff (reset)
      gen_cmd.step |-> gen_seeded)
      else $error("generator stepped while not seeded");

   // Nothing is left running when a new request can be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!div_busy && !gen_busy))
      else $error("work in flight while idle");

endmodule

>>> sv/xrng_div.sv
// ----------------------------------------------------------------------------
// xrng_div
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xrng_div #(
   parameter int WIDTH = xrng_pkg::WORD_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] rem
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] shr_ff, shr_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // Shift the next dividend bit into the partial remainder and trial-subtract
   always_comb begin
      trial   = {rem_ff, shr_ff[WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      shr_in  = shr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         shr_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         shr_in = shr_ff << 1;
         rem_in = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      shr_ff <= shr_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

>>> sv/xrng_gen.sv
// ----------------------------------------------------------------------------
// xrng_gen
// xoshiro256++ state, state update and a two-stage output pipeline.
// ----------------------------------------------------------------------------
module xrng_gen (
   input  logic                       clock,
   input  logic                       reset,
   input  xrng_pkg::gen_cmd_type      cmd,
   input  xrng_pkg::seed_type         seed,
   output logic                       seeded,
   output logic                       busy,
   output logic                       out_valid,
   output logic [xrng_pkg::WORD_W-1:0] out_word
);

   localparam int W = xrng_pkg::WORD_W;

   logic [W-1:0] s_ff [xrng_pkg::NUM_WORDS];
   logic [W-1:0] s_in [xrng_pkg::NUM_WORDS];
   logic         seeded_ff, seeded_in;
   logic [W-1:0] sum_ff, s0_ff;
   logic         sum_v_ff;
   logic [W-1:0] out_ff;
   logic         out_v_ff;
   logic [W-1:0] t;
   logic [W-1:0] x3;

   // Next state: load seeds or advance one step
   always_comb begin
      t         = s_ff[1] << xrng_pkg::SHIFT_T;
      x3        = s_ff[3] ^ s_ff[1];
      seeded_in = seeded_ff;
      for (int i = 0; i < xrng_pkg::NUM_WORDS; i++) begin
         s_in[i] = s_ff[i];
      end
      if (cmd.load) begin
         seeded_in = 1'b1;
         for (int i = 0; i < xrng_pkg::NUM_WORDS; i++) begin
            s_in[i] = seed[i];
         end
      end else if (cmd.step) begin
         s_in[0] = s_ff[0] ^ x3;
         s_in[1] = s_ff[1] ^ s_ff[2] ^ s_ff[0];
         s_in[2] = s_ff[2] ^ s_ff[0] ^ t;
         s_in[3] = xrng_pkg::rotl(x3, xrng_pkg::ROT_S3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         sum_v_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         seeded_ff <= seeded_in;
         sum_v_ff  <= cmd.step;
         out_v_ff  <= sum_v_ff;
      end
      for (int i = 0; i < xrng_pkg::NUM_WORDS; i++) begin
         s_ff[i] <= s_in[i];
      end
      // Output: sum of outer words, then rotate and add
      if (cmd.step) begin
         sum_ff <= s_ff[0] + s_ff[3];
         s0_ff  <= s_ff[0];
      end
      if (sum_v_ff) begin
         out_ff <= xrng_pkg::rotl(sum_ff, xrng_pkg::ROT_SUM) + s0_ff;
      end
   end

   assign seeded    = seeded_ff;
   assign busy      = sum_v_ff | out_v_ff;
   assign out_valid = out_v_ff;
   assign out_word  = out_ff;

endmodule

>>> dv/xrng_checker.sv
// ----------------------------------------------------------------------------
// xrng_checker
// Watches the request, response and register-write ports of the xoshiro256++
// core. It keeps its own copy of the generator state and seed registers,
// computes the response for every accepted request and compares each
// accepted response with the oldest one still awaited.
// ----------------------------------------------------------------------------
module xrng_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [xrng_pkg::OPC_W-1:0]    req_opcode,
   input  logic [xrng_pkg::WORD_W-1:0]   req_range_low,
   input  logic [xrng_pkg::WORD_W-1:0]   req_range_high,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [xrng_pkg::WORD_W-1:0]   rsp_value,
   input  logic [xrng_pkg::STAT_W-1:0]   rsp_status,
   input  logic                          csr_we,
   input  logic [xrng_pkg::IDX_W-1:0]    csr_index,
   input  logic [xrng_pkg::WORD_W-1:0]   csr_wdata,
   output int                            fail_count = 0,
   output int                            outstanding = 0
);

   localparam int W = xrng_pkg::WORD_W;

   typedef struct packed {
      logic [W-1:0]         value;
      xrng_pkg::status_type status;
   } rng_response_type;

   logic [W-1:0]      gen_words  [xrng_pkg::NUM_WORDS];
   logic [W-1:0]      seed_words [xrng_pkg::NUM_WORDS];
   rng_response_type  awaited_responses [$];

   function automatic logic [W-1:0] rotate_left(input logic [W-1:0] x, input int k);
      return (x << k) | (x >> (W - k));
   endfunction

   // One xoshiro256++ step: output word, then state update
   function automatic logic [W-1:0] step_generator();
      logic [W-1:0] out_word;
      logic [W-1:0] shifted;
      out_word = rotate_left(gen_words[0] + gen_words[3], xrng_pkg::ROT_SUM)
                 + gen_words[0];
      shifted = gen_words[1] << xrng_pkg::SHIFT_T;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= shifted;
      gen_words[3] = rotate_left(gen_words[3], xrng_pkg::ROT_S3);
      return out_word;
   endfunction

   // Response of one request; advances the local generator copy
   function automatic rng_response_type next_response(input xrng_pkg::opcode_type op,
                                                      input logic [W-1:0] lo,
                                                      input logic [W-1:0] hi);
      rng_response_type rsp;
      logic [W-1:0]     span;
      logic [W-1:0]     limit;
      logic [W-1:0]     draw;
      logic             state_zero;
      rsp.value  = '0;
      rsp.status = xrng_pkg::ST_OK;
      state_zero = (gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == '0;
      case (op)
         xrng_pkg::OP_RESEED: begin
            if ((seed_words[0] | seed_words[1] | seed_words[2] | seed_words[3]) == '0)
               rsp.status = xrng_pkg::ST_ZERO_SEED;
            else
               gen_words = seed_words;
         end
         xrng_pkg::OP_RAW: begin
            if (state_zero) rsp.status = xrng_pkg::ST_NOT_SEEDED;
            else rsp.value = step_generator();
         end
         xrng_pkg::OP_BOUNDED: begin
            if (state_zero) begin
               rsp.status = xrng_pkg::ST_NOT_SEEDED;
            end else if (hi <= lo || hi - lo == 64'd1) begin
               // degenerate range: no draw taken
               rsp.value = lo;
            end else begin
               span  = hi - lo;
               limit = (64'd0 - span) % span;
               do begin
                  draw = step_generator();
               end while (draw < limit);
               rsp.value = lo + draw % span;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // Sample all ports at the clock edge; responses are retired before new
   // requests are queued
   always @(posedge clock) begin : monitor
      rng_response_type want;
      int               bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < xrng_pkg::NUM_WORDS; i++) begin
            gen_words[i]  = '0;
            seed_words[i] = '0;
         end
         awaited_responses.delete();
         outstanding <= 0;
         fail_count  <= 0;
      end else begin
         if (csr_we) seed_words[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: response with none awaited, value %h status %0d",
                        $time, rsp_value, rsp_status);
               bad++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_value);
                  bad++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  bad++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_responses.push_back(
               next_response(xrng_pkg::opcode_type'(req_opcode),
                             req_range_low, req_range_high));
         outstanding <= awaited_responses.size();
         fail_count  <= fail_count + bad;
      end
   end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the xoshiro256++ bounded RNG core: a directed pass over unseeded
// draws, zero seeds, degenerate and wide ranges, then phases of random
// requests under new seeds with random gaps on both channels. The checker
// predicts and compares; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int W           = xrng_pkg::WORD_W;
   localparam int NW          = xrng_pkg::NUM_WORDS;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 100;
   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

   logic                               clock;
   logic                               reset          = 1'b1;
   logic                               req_valid      = 1'b0;
   logic                               req_ready;
   logic [xrng_pkg::OPC_W-1:0]         req_opcode     = '0;
   logic [W-1:0]                       req_range_low  = '0;
   logic [W-1:0]                       req_range_high = '0;
   logic                               rsp_valid;
   logic                               rsp_ready      = 1'b0;
   logic [W-1:0]                       rsp_value;
   logic [xrng_pkg::STAT_W-1:0]        rsp_status;
   logic                               csr_we         = 1'b0;
   logic [xrng_pkg::IDX_W-1:0]         csr_index      = '0;
   logic [W-1:0]                       csr_wdata      = '0;
   int                                 fail_count;
   int                                 outstanding;

   bit                                 send_calm      = 1'b0;
   logic                               ready_calm     = 1'b0;
   int                                 stall_left     = 0;
   int                                 quiet_cycles   = 0;

   xoshiro256pp_bounded_rng_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   xrng_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response back-pressure: mostly ready, short stalls, a few long ones
   always @(posedge clock) begin : ready_gen
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (ready_calm || pick < 65) begin
         rsp_ready <= 1'b1;
      end else if (pick < 94) begin
         rsp_ready  <= 1'b0;
         stall_left <= int'($urandom_range(0, 3));
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= int'($urandom_range(10, 60));
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("xoshiro256pp_bounded_rng_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int idle_gap();
      int unsigned pick;
      if (send_calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 60));
   endfunction

   function automatic logic [W-1:0] random_seed_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return rand_word();
      if (pick < 90) return 64'd1 << $urandom_range(0, 63);
      if (pick < 95) return ALL_ONES;
      return '0;
   endfunction

   function automatic xrng_pkg::opcode_type random_opcode();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return xrng_pkg::OP_RAW;
      if (pick < 80) return xrng_pkg::OP_BOUNDED;
      if (pick < 93) return xrng_pkg::OP_RESEED;
      return xrng_pkg::OP_NOP;
   endfunction

   // Range mix: narrow, small, wide, near half-range (heavy rejection),
   // power-of-two spans and degenerate ranges
   task automatic pick_range(output logic [W-1:0] lo, output logic [W-1:0] hi);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      lo = rand_word();
      if (pick < 30) begin
         hi = lo + 64'($urandom_range(0, 40));
      end else if (pick < 45) begin
         lo = 64'($urandom_range(0, 1000));
         hi = 64'($urandom_range(0, 1000));
      end else if (pick < 65) begin
         hi = rand_word();
      end else if (pick < 77) begin
         lo = 64'($urandom_range(0, 1000));
         hi = lo + TOP_BIT + 64'($urandom_range(0, 1000));
      end else if (pick < 85) begin
         lo = 64'($urandom_range(0, 1000));
         hi = lo + (64'd1 << $urandom_range(1, 62));
      end else if (pick < 92) begin
         lo = '0;
         hi = ($urandom_range(0, 1) != 0) ? ALL_ONES : rand_word();
      end else begin
         pick = $urandom_range(0, 2);
         if (pick == 0) hi = lo;
         else if (pick == 1) hi = lo + 64'd1;
         else begin
            lo = ALL_ONES;
            hi = rand_word();
         end
      end
   endtask

   // Present one request and return at the edge where it is taken
   task automatic send_request(input xrng_pkg::opcode_type op, input logic [W-1:0] lo,
                               input logic [W-1:0] hi);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_range_low  <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every awaited response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write the selected seed registers on consecutive cycles
   task automatic write_seeds(input xrng_pkg::seed_type words, input logic [NW-1:0] mask);
      for (int unsigned i = 0; i < NW; i++) begin
         if (mask[i]) begin
            csr_we    <= 1'b1;
            csr_index <= i[xrng_pkg::IDX_W-1:0];
            csr_wdata <= words[i];
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      xrng_pkg::seed_type   seeds;
      logic [NW-1:0]        mask;
      logic [W-1:0]         lo;
      logic [W-1:0]         hi;
      xrng_pkg::opcode_type op;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Unseeded generator: draws refused, zero seed refused, unused opcode
      send_request(xrng_pkg::OP_RAW, '0, '0);
      send_request(xrng_pkg::OP_BOUNDED, 64'd5, 64'd6);
      send_request(xrng_pkg::OP_BOUNDED, '0, 64'd100);
      send_request(xrng_pkg::OP_RESEED, '0, '0);
      send_request(xrng_pkg::OP_NOP, ALL_ONES, ALL_ONES);

      // Sparse seed, then range corner cases
      wait_idle();
      seeds = '0;
      seeds[3] = 64'd1;
      write_seeds(seeds, '1);
      send_request(xrng_pkg::OP_RESEED, '0, '0);
      send_request(xrng_pkg::OP_RAW, '0, '0);
      send_request(xrng_pkg::OP_RAW, ALL_ONES, ALL_ONES);
      send_request(xrng_pkg::OP_BOUNDED, '0, '0);
      send_request(xrng_pkg::OP_BOUNDED, 64'd5, 64'd6);
      send_request(xrng_pkg::OP_BOUNDED, 64'd10, 64'd3);
      send_request(xrng_pkg::OP_BOUNDED, ALL_ONES, ALL_ONES);
      send_request(xrng_pkg::OP_BOUNDED, ALL_ONES, '0);
      send_request(xrng_pkg::OP_BOUNDED, '0, ALL_ONES);
      send_request(xrng_pkg::OP_BOUNDED, '0, 64'd2);
      send_request(xrng_pkg::OP_BOUNDED, '0, TOP_BIT + 64'd1);
      send_request(xrng_pkg::OP_BOUNDED, '0, TOP_BIT);
      send_request(xrng_pkg::OP_BOUNDED, 64'd100, 64'd107);
      send_request(xrng_pkg::OP_NOP, '0, '0);

      // All-ones seed
      wait_idle();
      seeds = {NW{ALL_ONES}};
      write_seeds(seeds, '1);
      send_request(xrng_pkg::OP_RESEED, '0, '0);
      send_request(xrng_pkg::OP_RAW, '0, '0);
      send_request(xrng_pkg::OP_BOUNDED, '0, 64'd3);

      // Zero seed refused; the running state must survive it
      wait_idle();
      write_seeds('0, '1);
      send_request(xrng_pkg::OP_RESEED, '0, '0);
      send_request(xrng_pkg::OP_RAW, '0, '0);

      // Random phases, each under a new seed set
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         for (int w = 0; w < NW; w++) seeds[w] = random_seed_word();
         if (phase == 3) seeds = '0;
         mask = (phase == 0 || phase == 3) ? '1 : NW'($urandom_range(1, 15));
         write_seeds(seeds, mask);
         send_calm = (phase == 2);
         ready_calm <= (phase == 4);
         send_request(xrng_pkg::OP_RESEED, rand_word(), rand_word());
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // drain once mid-phase
            if (item == PHASE_ITEMS / 2) wait_idle();
            op = random_opcode();
            pick_range(lo, hi);
            send_request(op, lo, hi);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("xoshiro256pp_bounded_rng_core regression: pass");
      else
         $display("xoshiro256pp_bounded_rng_core regression: fail");
      $finish;
   end

endmodule
